>>> src/vpr_pkg.sv
// Shared types, constants and helpers for the velocity PID controller with ramp.
package vpr_pkg;

  // Fixed loop constants
  localparam int SAMPLE_RATE = 10;
  localparam int SCALE       = 256;
  localparam int SCALE_SHIFT = $clog2(SCALE);
  localparam int OUT_LIMIT   = 32767;

  // Field and datapath widths
  localparam int GAIN_W      = 16;
  localparam int DATA_W      = 16;
  localparam int REG_INDEX_W = 2;
  localparam int DX_W        = DATA_W + 1;              // first difference of x
  localparam int DDX_W       = DX_W + 1;                // second difference of x
  localparam int ERR_W       = 21;                      // slope minus rate times dx
  localparam int DE_W        = ERR_W + 1;               // error change
  localparam int EMAG_W      = ERR_W - 1;               // error magnitude
  localparam int KI_QUOT_W   = $clog2(65535 / SAMPLE_RATE + 1);
  localparam int KI_REM_W    = $clog2(SAMPLE_RATE);
  localparam int P_W         = GAIN_W + 1 + DE_W;       // Kp times error change
  localparam int D_W         = GAIN_W + 1 + DDX_W;      // Kd times second difference
  localparam int D10_W       = D_W + 4;                 // times sample rate
  localparam int IQ_W        = KI_QUOT_W + EMAG_W;
  localparam int IR_W        = KI_REM_W + EMAG_W;
  localparam int I_W         = IQ_W + 2;
  localparam int SUM_W       = D10_W + 1;
  localparam int Q_W         = SUM_W - SCALE_SHIFT;
  localparam int U_W         = Q_W + 1;

  // Reciprocal of the sample rate, exact for operands below 2**26
  localparam int RECIP_SHIFT = 27;
  localparam int RECIP_W     = 24;
  localparam int RECIP       = (2 ** RECIP_SHIFT + SAMPLE_RATE - 1) / SAMPLE_RATE;
  localparam int RPROD_W     = IR_W + RECIP_W;
  localparam int DIVQ_W      = RPROD_W - RECIP_SHIFT;

  // Register indexes
  localparam logic [REG_INDEX_W-1:0] REG_PROP_GAIN     = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_INTEGRAL_GAIN = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_DERIV_GAIN    = 2'd2;

  // Mode command codes
  localparam logic [2:0] CMD_STOP   = 3'd0;
  localparam logic [2:0] CMD_OFF    = 3'd1;
  localparam logic [2:0] CMD_NORMAL = 3'd2;
  localparam logic [2:0] CMD_RAMP   = 3'd3;

  typedef enum logic [1:0] {
    MODE_STOP   = 2'd0,
    MODE_OFF    = 2'd1,
    MODE_NORMAL = 2'd2,
    MODE_RAMP   = 2'd3
  } loop_mode_t;

  // What the output stage does with the channel's drive
  typedef enum logic [1:0] {
    DRV_HOLD  = 2'd0,
    DRV_CLEAR = 2'd1,
    DRV_STEP  = 2'd2,
    DRV_IDLE  = 2'd3
  } drive_op_t;

  typedef struct packed {
    logic                     mode;
    logic [1:0]               channel;
    logic signed [DATA_W-1:0] process_value;
    logic [2:0]               new_mode;
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] ramp_target;
    logic signed [DATA_W-1:0] ramp_slope;
  } item_t;

  typedef struct packed {
    logic [1:0]               out_channel;
    logic signed [DATA_W-1:0] drive;
    logic [1:0]               current_mode;
  } result_t;

  typedef struct packed {
    logic [GAIN_W-1:0]    kp;
    logic [GAIN_W-1:0]    kd;
    logic [KI_QUOT_W-1:0] ki_quot;
    logic [KI_REM_W-1:0]  ki_rem;
    logic                 ki_zero;
  } gains_t;

  typedef struct packed {
    logic [1:0]              channel;
    loop_mode_t              mode;
    drive_op_t               op;
    logic signed [DE_W-1:0]  p_op;
    logic signed [DDX_W-1:0] d_op;
    logic                    e_neg;
    logic [EMAG_W-1:0]       e_mag;
  } front_t;

  typedef struct packed {
    logic [1:0]            channel;
    loop_mode_t            mode;
    drive_op_t             op;
    logic signed [P_W-1:0] p_prod;
    logic signed [D_W-1:0] d_prod;
    logic [IQ_W-1:0]       iq_prod;
    logic [IR_W-1:0]       ir_prod;
    logic                  e_neg;
  } prod_t;

  typedef struct packed {
    logic [1:0]              channel;
    loop_mode_t              mode;
    drive_op_t               op;
    logic signed [P_W-1:0]   p;
    logic signed [I_W-1:0]   i;
    logic signed [D10_W-1:0] d10;
  } term_t;

  // Floor division by the sample rate through a reciprocal multiply
  function automatic logic [DIVQ_W-1:0] div_rate(input logic [IR_W-1:0] x);
    logic [RPROD_W-1:0] prod;
    prod = RPROD_W'(x) * RPROD_W'(RECIP);
    return prod[RPROD_W-1:RECIP_SHIFT];
  endfunction

endpackage

>>> src/velocity_pid_with_ramp.sv
// Multi-channel velocity-form PID controller with setpoint ramp.
//
// Input words arrive on item_valid/item_stall with an item payload: either a
// process sample or a mode command for one channel. Every accepted word gives
// exactly one result word on result_valid/result_stall, carrying the channel,
// the channel's drive after the word and its mode.
// A word passes the input register, then the loop state, gain product, rate
// division and drive update registers before it shows up as result_valid.
// Throughput: one word per cycle while result_stall is low; each channel's state
// and drive are updated in order, so words for the same channel may follow back
// to back. Gains are written on the cfg port (cfg_valid/cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high. The user must write gains only while no
// word is in flight; the block does not enforce it. Reset clears the gains,
// every channel to stop mode with zero state and drive, and empties the
// pipeline. When result_stall is high the result word holds; the pipeline
// keeps taking words until its stages fill, then raises item_stall.
module velocity_pid_with_ramp #(
  parameter int CHANNELS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  vpr_pkg::item_t                   item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output vpr_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vpr_pkg::REG_INDEX_W-1:0]  cfg_index,
  input  logic [vpr_pkg::GAIN_W-1:0]       cfg_data
);

  vpr_pkg::gains_t gains;
  vpr_pkg::front_t front;
  vpr_pkg::term_t  term;
  logic            front_valid;
  logic            front_stall;
  logic            term_valid;
  logic            term_stall;

  assign cfg_ready = 1'b1;

  vpr_gains u_gains (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  vpr_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .gains      (gains),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .dn_valid   (front_valid),
    .dn_stall   (front_stall),
    .front      (front)
  );

  vpr_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .gains    (gains),
    .up_valid (front_valid),
    .up_stall (front_stall),
    .front    (front),
    .dn_valid (term_valid),
    .dn_stall (term_stall),
    .term     (term)
  );

  vpr_drive #(
    .CHANNELS (CHANNELS)
  ) u_drive (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (term_valid),
    .up_stall     (term_stall),
    .term         (term),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> src/vpr_gains.sv
// Gain registers, with the integral gain split into quotient and remainder of the rate.
module vpr_gains (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [vpr_pkg::REG_INDEX_W-1:0]  cfg_index,
  input  logic [vpr_pkg::GAIN_W-1:0]       cfg_data,
  output vpr_pkg::gains_t                  gains
);

  logic [vpr_pkg::DIVQ_W-1:0] ki_q;
  logic [vpr_pkg::IR_W-1:0]   ki_r;

  always_comb begin
    ki_q = vpr_pkg::div_rate(vpr_pkg::IR_W'(cfg_data));
    ki_r = vpr_pkg::IR_W'(cfg_data)
         - vpr_pkg::IR_W'(ki_q) * vpr_pkg::IR_W'(vpr_pkg::SAMPLE_RATE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '{kp: '0, kd: '0, ki_quot: '0, ki_rem: '0, ki_zero: 1'b1};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vpr_pkg::REG_PROP_GAIN: begin
          gains.kp <= cfg_data;
        end
        vpr_pkg::REG_INTEGRAL_GAIN: begin
          gains.ki_quot <= ki_q[vpr_pkg::KI_QUOT_W-1:0];
          gains.ki_rem  <= ki_r[vpr_pkg::KI_REM_W-1:0];
          gains.ki_zero <= (cfg_data == '0);
        end
        vpr_pkg::REG_DERIV_GAIN: begin
          gains.kd <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/vpr_front.sv
// Input register, per-channel loop state, mode handling and error differences.
module vpr_front #(
  parameter int CHANNELS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  vpr_pkg::gains_t  gains,
  input  logic             item_valid,
  output logic             item_stall,
  input  vpr_pkg::item_t   item,
  output logic             dn_valid,
  input  logic             dn_stall,
  output vpr_pkg::front_t  front
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef struct packed {
    vpr_pkg::loop_mode_t              mode;
    logic signed [vpr_pkg::DATA_W-1:0] setpoint;
    logic signed [vpr_pkg::DATA_W-1:0] target;
    logic signed [vpr_pkg::DATA_W-1:0] slope;
    logic signed [vpr_pkg::DATA_W-1:0] last_pv;
    logic signed [vpr_pkg::ERR_W-1:0]  last_err;
    logic signed [vpr_pkg::DX_W-1:0]   last_dx;
  } loop_t;

  loop_t                              loops [CHANNELS];
  loop_t                              cur;
  loop_t                              loop_next;
  vpr_pkg::item_t                     s0;
  logic                               s0_v;
  logic                               s0_ready;
  logic                               s0_adv;
  logic                               s1_ready;
  logic                               in_range;
  logic [IDX_W-1:0]                   idx;
  vpr_pkg::front_t                    front_next;
  logic signed [vpr_pkg::DX_W-1:0]    dx;
  logic signed [vpr_pkg::DDX_W-1:0]   ddx;
  logic signed [vpr_pkg::ERR_W-1:0]   err;
  logic signed [vpr_pkg::ERR_W-1:0]   err_abs;
  logic signed [vpr_pkg::DE_W-1:0]    de;
  logic                               ramp_done;
  logic                               flip;

  assign s1_ready   = !dn_valid || !dn_stall;
  assign s0_ready   = !s0_v || s1_ready;
  assign s0_adv     = s0_v && s1_ready;
  assign item_stall = !s0_ready;

  assign in_range = int'(s0.channel) < CHANNELS;
  assign idx      = in_range ? IDX_W'(s0.channel) : '0;

  always_comb begin
    cur = loops[idx];
    loop_next = cur;

    dx = vpr_pkg::DX_W'(s0.process_value) - vpr_pkg::DX_W'(cur.last_pv);
    if (cur.mode == vpr_pkg::MODE_RAMP) begin
      err = vpr_pkg::ERR_W'(cur.slope)
          - vpr_pkg::ERR_W'(dx) * vpr_pkg::ERR_W'(vpr_pkg::SAMPLE_RATE);
    end else begin
      err = vpr_pkg::ERR_W'(cur.setpoint) - vpr_pkg::ERR_W'(s0.process_value);
    end
    ddx     = vpr_pkg::DDX_W'(dx) - vpr_pkg::DDX_W'(cur.last_dx);
    de      = vpr_pkg::DE_W'(err) - vpr_pkg::DE_W'(cur.last_err);
    err_abs = err[vpr_pkg::ERR_W-1] ? -err : err;

    ramp_done = (s0.process_value >= cur.target && cur.slope > 0)
             || (s0.process_value <= cur.target && cur.slope < 0)
             || (cur.slope == '0);
    flip = (cur.last_pv > s0.ramp_target && s0.ramp_slope > 0)
        || (cur.last_pv < s0.ramp_target && s0.ramp_slope < 0);

    front_next = '0;
    front_next.channel = s0.channel;
    front_next.op = vpr_pkg::DRV_HOLD;

    if (!in_range) begin
      front_next.op = vpr_pkg::DRV_IDLE;
    end else if (s0.mode) begin
      // load all three values, then apply the transition
      loop_next.setpoint = s0.setpoint;
      loop_next.target   = s0.ramp_target;
      loop_next.slope    = s0.ramp_slope;
      unique case (s0.new_mode)
        vpr_pkg::CMD_OFF: begin
          loop_next = '0;
          loop_next.mode = vpr_pkg::MODE_OFF;
          front_next.op = vpr_pkg::DRV_CLEAR;
        end
        vpr_pkg::CMD_NORMAL: begin
          loop_next.mode = vpr_pkg::MODE_NORMAL;
        end
        vpr_pkg::CMD_RAMP: begin
          // turn the slope toward the target
          if (flip) begin
            loop_next.slope = (s0.ramp_slope == -16'sd32768) ? 16'sd32767 : -s0.ramp_slope;
          end
          loop_next.mode = vpr_pkg::MODE_RAMP;
        end
        default: begin
          loop_next.mode = vpr_pkg::MODE_STOP;
        end
      endcase
    end else begin
      unique case (cur.mode)
        vpr_pkg::MODE_NORMAL, vpr_pkg::MODE_RAMP: begin
          loop_next.last_dx  = dx;
          loop_next.last_err = err;
          loop_next.last_pv  = s0.process_value;
          if (cur.mode == vpr_pkg::MODE_RAMP && ramp_done) begin
            loop_next.setpoint = cur.target;
            loop_next.mode     = vpr_pkg::MODE_NORMAL;
          end
          front_next.op   = vpr_pkg::DRV_STEP;
          front_next.d_op = -ddx;
          if (gains.ki_zero) begin
            front_next.p_op = de;
          end else begin
            front_next.p_op  = -vpr_pkg::DE_W'(dx);
            front_next.e_neg = err[vpr_pkg::ERR_W-1];
            front_next.e_mag = err_abs[vpr_pkg::EMAG_W-1:0];
          end
        end
        vpr_pkg::MODE_OFF: begin
          loop_next.mode = vpr_pkg::MODE_STOP;
        end
        vpr_pkg::MODE_STOP: begin
        end
      endcase
    end

    front_next.mode = in_range ? loop_next.mode : vpr_pkg::MODE_STOP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v     <= 1'b0;
      dn_valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        loops[c] <= '0;
      end
    end else begin
      if (s0_ready) begin
        s0_v <= item_valid;
      end
      if (s1_ready) begin
        dn_valid <= s0_v;
      end
      if (s0_adv && in_range) begin
        loops[idx] <= loop_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && item_valid) begin
      s0 <= item;
    end
    if (s0_adv) begin
      front <= front_next;
    end
  end

endmodule

>>> src/vpr_mult.sv
// Gain products, then integral division by the rate and derivative scaling.
module vpr_mult (
  input  logic             clk,
  input  logic             rst,
  input  vpr_pkg::gains_t  gains,
  input  logic             up_valid,
  output logic             up_stall,
  input  vpr_pkg::front_t  front,
  output logic             dn_valid,
  input  logic             dn_stall,
  output vpr_pkg::term_t   term
);

  vpr_pkg::prod_t               prod;
  vpr_pkg::prod_t               prod_next;
  vpr_pkg::term_t               term_next;
  logic                         prod_v;
  logic                         prod_ready;
  logic                         term_ready;
  logic [vpr_pkg::DIVQ_W-1:0]   ir_quot;
  logic [vpr_pkg::I_W-2:0]      i_mag;

  assign term_ready = !dn_valid || !dn_stall;
  assign prod_ready = !prod_v || term_ready;
  assign up_stall   = !prod_ready;

  always_comb begin
    prod_next.channel = front.channel;
    prod_next.mode    = front.mode;
    prod_next.op      = front.op;
    prod_next.e_neg   = front.e_neg;
    prod_next.p_prod  = vpr_pkg::P_W'($signed({1'b0, gains.kp})) * vpr_pkg::P_W'(front.p_op);
    prod_next.d_prod  = vpr_pkg::D_W'($signed({1'b0, gains.kd})) * vpr_pkg::D_W'(front.d_op);
    prod_next.iq_prod = vpr_pkg::IQ_W'(gains.ki_quot) * vpr_pkg::IQ_W'(front.e_mag);
    prod_next.ir_prod = vpr_pkg::IR_W'(gains.ki_rem) * vpr_pkg::IR_W'(front.e_mag);
  end

  always_comb begin
    ir_quot = vpr_pkg::div_rate(prod.ir_prod);
    i_mag   = (vpr_pkg::I_W - 1)'(prod.iq_prod) + (vpr_pkg::I_W - 1)'(ir_quot);
    term_next.channel = prod.channel;
    term_next.mode    = prod.mode;
    term_next.op      = prod.op;
    term_next.p       = prod.p_prod;
    // truncate toward zero: divide the magnitude, then restore the sign
    term_next.i = prod.e_neg ? -$signed({1'b0, i_mag}) : $signed({1'b0, i_mag});
    term_next.d10 = vpr_pkg::D10_W'(prod.d_prod) * vpr_pkg::D10_W'(vpr_pkg::SAMPLE_RATE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v   <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_v <= up_valid;
      end
      if (term_ready) begin
        dn_valid <= prod_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && up_valid) begin
      prod <= prod_next;
    end
    if (term_ready && prod_v) begin
      term <= term_next;
    end
  end

endmodule

>>> src/vpr_drive.sv
// Increment sum, scaling, per-channel drive accumulation and saturation.
module vpr_drive #(
  parameter int CHANNELS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_stall,
  input  vpr_pkg::term_t   term,
  output logic             result_valid,
  input  logic             result_stall,
  output vpr_pkg::result_t result
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [vpr_pkg::U_W-1:0] LIM_HI = vpr_pkg::U_W'(vpr_pkg::OUT_LIMIT);
  localparam logic signed [vpr_pkg::U_W-1:0] LIM_LO = -LIM_HI;

  logic signed [vpr_pkg::DATA_W-1:0] last_drive [CHANNELS];
  logic signed [vpr_pkg::DATA_W-1:0] prev;
  logic signed [vpr_pkg::DATA_W-1:0] drive_next;
  logic signed [vpr_pkg::SUM_W-1:0]  sum;
  logic signed [vpr_pkg::SUM_W-1:0]  biased;
  logic signed [vpr_pkg::Q_W-1:0]    quot;
  logic signed [vpr_pkg::U_W-1:0]    total;
  logic [IDX_W-1:0]                  idx;
  logic                              r_ready;
  logic                              commit;

  assign r_ready  = !result_valid || !result_stall;
  assign up_stall = !r_ready;
  assign commit   = up_valid && r_ready;
  assign idx      = (term.op == vpr_pkg::DRV_IDLE) ? '0 : IDX_W'(term.channel);

  always_comb begin
    prev = last_drive[idx];
    sum = vpr_pkg::SUM_W'(term.p) + vpr_pkg::SUM_W'(term.i) + vpr_pkg::SUM_W'(term.d10);
    // bias negative sums so the shift truncates toward zero
    biased = sum[vpr_pkg::SUM_W-1] ? sum + vpr_pkg::SUM_W'(vpr_pkg::SCALE - 1) : sum;
    quot  = $signed(biased[vpr_pkg::SUM_W-1:vpr_pkg::SCALE_SHIFT]);
    total = vpr_pkg::U_W'(prev) + vpr_pkg::U_W'(quot);
    unique case (term.op)
      vpr_pkg::DRV_STEP: begin
        if (total > LIM_HI) begin
          drive_next = LIM_HI[vpr_pkg::DATA_W-1:0];
        end else if (total < LIM_LO) begin
          drive_next = LIM_LO[vpr_pkg::DATA_W-1:0];
        end else begin
          drive_next = total[vpr_pkg::DATA_W-1:0];
        end
      end
      vpr_pkg::DRV_HOLD: drive_next = prev;
      vpr_pkg::DRV_CLEAR, vpr_pkg::DRV_IDLE: drive_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        last_drive[c] <= '0;
      end
    end else begin
      if (r_ready) begin
        result_valid <= up_valid;
      end
      if (commit && term.op != vpr_pkg::DRV_IDLE) begin
        last_drive[idx] <= drive_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.out_channel  <= term.channel;
      result.drive        <= drive_next;
      result.current_mode <= term.mode;
    end
  end

endmodule
